>>> rtl/core/ptrm_pkg.sv
// Package for the page table region manager: command and result structs,
// operation and status codes, memory entry layouts. No dependencies.
package ptrm_pkg;

  localparam int TAB_BITS = 10;  // table index width (1024 entries per table)

  localparam logic [2:0] OP_TRANSLATE = 3'd0;
  localparam logic [2:0] OP_ALLOCATE = 3'd1;
  localparam logic [2:0] OP_FREE = 3'd2;
  localparam logic [2:0] OP_ASSIGN = 3'd3;
  localparam logic [2:0] OP_DIR_WRITE = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_NO_RUN = 2'd2;

  localparam logic [1:0] REG_USER_LOW = 2'd0;
  localparam logic [1:0] REG_USER_HIGH = 2'd1;
  localparam logic [1:0] REG_KERNEL_LOW = 2'd2;
  localparam logic [1:0] REG_KERNEL_HIGH = 2'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [31:0] vaddr;
    logic [19:0] phys_frame;
    logic [31:0] byte_count;
    logic [20:0] page_count;
    logic [31:0] align_bytes;
    logic read_only;
    logic user_access;
    logic kernel_space;
    logic dir_present;
    logic dir_large;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] paddr;
    logic [31:0] region_begin;
    logic [20:0] region_pages;
  } rsp_t;

  typedef struct packed {
    logic present;
    logic big;
    logic [19:0] frame;
  } dir_ent_t;

  typedef struct packed {
    logic [19:0] frame;
    logic user;
    logic writable;
    logic present;
  } tab_ent_t;

endpackage

>>> rtl/core/page_table_region_manager_core.sv
// Top level of the page table region manager: config registers, directory and
// page table memories, sequencer. Depends on ptrm_pkg and ptrm_mod.
//
// Usage: after reset the block clears its directory memory with busy high. A
// command is taken when start is high and busy low; its result appears on
// rsp with done high for exactly one cycle, and the receiver cannot stall
// it. The block has one directory read port and one table read port, both
// with registered reads. An allocation runs two remainder passes for the
// alignment before it scans; a zero-byte allocation ends without them.
module page_table_region_manager_core #(
  parameter int DIR_ENTRIES = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ptrm_pkg::cmd_t cmd,
  output logic          done,
  output ptrm_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import ptrm_pkg::*;

  localparam int DW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int AW = DW + TAB_BITS;
  localparam int TAB_DEPTH = DIR_ENTRIES * (1 << TAB_BITS);
  localparam logic [20:0] TOTAL_PAGES = 21'(TAB_DEPTH);

  typedef enum logic [15:0] {
    S_CLR      = 16'h0001,
    S_IDLE     = 16'h0002,
    S_DISPATCH = 16'h0004,
    S_TR_DIR   = 16'h0008,
    S_TR_TAB   = 16'h0010,
    S_MOD_STEP = 16'h0020,
    S_MOD_INIT = 16'h0040,
    S_SCAN_RD  = 16'h0080,
    S_SCAN_EV  = 16'h0100,
    S_MARK_RD  = 16'h0200,
    S_MARK_EV  = 16'h0400,
    S_MAKE_TAB = 16'h0800,
    S_WALK_RD  = 16'h1000,
    S_WALK_WR  = 16'h2000
  } state_t;

  state_t state;

  logic [31:0] user_low, user_high, kernel_low, kernel_high;
  cmd_t        cmd_q;
  logic [20:0] p_q, e_q, need_q, run_q;
  logic [19:0] first_q, f_q;
  logic [31:0] r_q, step_q;
  logic [TAB_BITS-1:0] clr_q;
  logic [DW-1:0] dclr_q;

  dir_ent_t dir_mem [DIR_ENTRIES];
  tab_ent_t tab_mem [TAB_DEPTH];
  dir_ent_t dir_rd, dir_wdata;
  tab_ent_t tab_rd, tab_wdata;
  logic [DW-1:0] dir_raddr, dir_waddr;
  logic [AW-1:0] tab_raddr, tab_waddr;
  logic dir_we, tab_we;

  logic        d_ok, pg_avail, mod_start, mod_done;
  logic [31:0] mod_dividend, mod_rem, align_eff, lo_sel, hi_sel;
  logic [32:0] r_sum, need_sum;
  logic [21:0] walk_sum;
  logic [20:0] scan_end, walk_end;
  logic [31:0] large_phys;

  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // decode of the held command
  assign d_ok = ({1'b0, cmd_q.vaddr[31:22]} < 11'(DIR_ENTRIES));
  assign align_eff = (cmd_q.align_bytes == '0) ? 32'd4096 : cmd_q.align_bytes;
  assign lo_sel = cmd_q.kernel_space ? kernel_low : user_low;
  assign hi_sel = cmd_q.kernel_space ? kernel_high : user_high;
  assign scan_end = ({1'b0, hi_sel[31:12]} > TOTAL_PAGES) ? TOTAL_PAGES
                                                         : {1'b0, hi_sel[31:12]};
  assign need_sum = {1'b0, cmd_q.byte_count} + 33'd4095;
  assign walk_sum = {2'b0, cmd_q.vaddr[31:12]} + {1'b0, cmd_q.page_count};
  assign walk_end = (walk_sum > {1'b0, TOTAL_PAGES}) ? TOTAL_PAGES : walk_sum[20:0];
  assign large_phys = {dir_rd.frame, 12'b0} + {10'b0, cmd_q.vaddr[21:0]};

  // a page is free under an absent slot or as a clear entry of a small table
  assign pg_avail = !dir_rd.present || (!dir_rd.big && !tab_rd.present);

  // alignment remainder of the next page
  assign r_sum = {1'b0, r_q} + {1'b0, step_q};

  // remainder unit: first 4096 mod align, then start page offset mod align
  assign mod_start = ((state == S_DISPATCH) && (cmd_q.op == OP_ALLOCATE)
                      && (need_sum[32:12] != '0)) || ((state == S_MOD_STEP) && mod_done);
  assign mod_dividend = (state == S_DISPATCH) ? 32'd4096 : {p_q[19:0], 12'b0};

  ptrm_mod u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(mod_dividend),
    .divisor(align_eff), .done(mod_done), .rem(mod_rem)
  );

  // read addresses
  assign dir_raddr = (state == S_DISPATCH) ? cmd_q.vaddr[DW+21:22] : p_q[DW+9:10];
  assign tab_raddr = (state == S_TR_DIR) ? cmd_q.vaddr[AW+11:12] : p_q[AW-1:0];

  // directory write port: clearing pass, directory write, table creation
  always_comb begin
    dir_we = 1'b0;
    dir_waddr = dclr_q;
    dir_wdata = '0;
    if (state == S_CLR) begin
      dir_we = 1'b1;
    end else if (state == S_DISPATCH && cmd_q.op == OP_DIR_WRITE && d_ok) begin
      dir_we = 1'b1;
      dir_waddr = cmd_q.vaddr[DW+21:22];
      dir_wdata = '{present: cmd_q.dir_present, big: cmd_q.dir_large,
                    frame: cmd_q.phys_frame};
    end else if (state == S_MARK_EV && !dir_rd.present) begin
      dir_we = 1'b1;
      dir_waddr = p_q[DW+9:10];
      dir_wdata = '{present: 1'b1, big: 1'b0, frame: dir_rd.frame};
    end
  end

  // table write port: free/assign update, mark, table clear
  always_comb begin
    tab_we = 1'b0;
    tab_waddr = p_q[AW-1:0];
    tab_wdata = tab_rd;
    if (state == S_WALK_WR) begin
      tab_we = 1'b1;
      if (cmd_q.op == OP_FREE) begin
        tab_wdata.present = 1'b0;
      end else begin
        tab_wdata.frame = f_q;
      end
    end else if (state == S_MARK_EV && dir_rd.present) begin
      tab_we = 1'b1;
      tab_wdata.present = 1'b1;
      tab_wdata.writable = !cmd_q.read_only;
      tab_wdata.user = cmd_q.user_access;
    end else if (state == S_MAKE_TAB) begin
      tab_we = 1'b1;
      tab_waddr = {p_q[DW+9:10], clr_q};
      tab_wdata = '0;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    dir_rd <= dir_mem[dir_raddr];
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
  end

  always_ff @(posedge clk) begin
    tab_rd <= tab_mem[tab_raddr];
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      user_low <= 32'h0010_0000;
      user_high <= 32'hC000_0000;
      kernel_low <= 32'hC040_0000;
      kernel_high <= 32'hFFC0_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_USER_LOW:    user_low <= cfg_data;
        REG_USER_HIGH:   user_high <= cfg_data;
        REG_KERNEL_LOW:  kernel_low <= cfg_data;
        REG_KERNEL_HIGH: kernel_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      dclr_q <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          dclr_q <= dclr_q + 1'b1;
          if (dclr_q == DW'(DIR_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            rsp <= '0;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (cmd_q.op) inside
            OP_TRANSLATE: begin
              if (d_ok) begin
                state <= S_TR_DIR;
              end else begin
                rsp.status <= ST_ABSENT;
                done <= 1'b1;
                state <= S_IDLE;
              end
            end
            OP_ALLOCATE: begin
              p_q <= {1'b0, lo_sel[31:12]};
              e_q <= scan_end;
              need_q <= need_sum[32:12];
              run_q <= '0;
              if (need_sum[32:12] == '0) begin
                done <= 1'b1;
                state <= S_IDLE;
              end else begin
                state <= S_MOD_STEP;
              end
            end
            OP_FREE, OP_ASSIGN: begin
              p_q <= {1'b0, cmd_q.vaddr[31:12]};
              e_q <= walk_end;
              f_q <= cmd_q.phys_frame;
              state <= S_WALK_RD;
            end
            default: begin
              done <= 1'b1;
              state <= S_IDLE;
            end
          endcase
        end
        S_TR_DIR: begin
          if (!dir_rd.present) begin
            rsp.status <= ST_ABSENT;
            done <= 1'b1;
            state <= S_IDLE;
          end else if (dir_rd.big) begin
            rsp.paddr <= large_phys;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_TR_TAB;
          end
        end
        S_TR_TAB: begin
          rsp.paddr <= {tab_rd.frame, cmd_q.vaddr[11:0]};
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_MOD_STEP: begin
          if (mod_done) begin
            step_q <= mod_rem;
            state <= S_MOD_INIT;
          end
        end
        S_MOD_INIT: begin
          if (mod_done) begin
            r_q <= mod_rem;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (run_q >= need_q) begin
            p_q <= {1'b0, first_q};
            run_q <= '0;
            state <= S_MARK_RD;
          end else if (p_q >= e_q) begin
            rsp.status <= ST_NO_RUN;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          // restart on a used page, open a run only on an aligned page
          if (!pg_avail) begin
            run_q <= '0;
          end else if (run_q == '0) begin
            if (r_q == '0) begin
              first_q <= p_q[19:0];
              run_q <= 21'd1;
            end
          end else begin
            run_q <= run_q + 21'd1;
          end
          p_q <= p_q + 21'd1;
          r_q <= (r_sum >= {1'b0, align_eff}) ? 32'(r_sum - {1'b0, align_eff})
                                               : r_sum[31:0];
          state <= S_SCAN_RD;
        end
        S_MARK_RD: begin
          if (run_q >= need_q) begin
            rsp.region_begin <= {first_q, 12'b0};
            rsp.region_pages <= need_q;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_MARK_EV;
          end
        end
        S_MARK_EV: begin
          if (!dir_rd.present) begin
            clr_q <= '0;
            state <= S_MAKE_TAB;
          end else begin
            p_q <= p_q + 21'd1;
            run_q <= run_q + 21'd1;
            state <= S_MARK_RD;
          end
        end
        S_MAKE_TAB: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state <= S_MARK_RD;
          end
        end
        S_WALK_RD: begin
          if (p_q >= e_q) begin
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_WALK_WR;
          end
        end
        S_WALK_WR: begin
          p_q <= p_q + 21'd1;
          f_q <= f_q + 20'd1;
          state <= S_WALK_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("result strobe outside a command");
  a_tab_addr: assert property (@(posedge clk) disable iff (rst)
    tab_we |-> ({1'b0, tab_waddr} < (AW+1)'(TAB_DEPTH)))
    else $error("table write beyond mapped space");
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_EV) |-> (run_q < need_q)) else $error("scan ran past need");
  a_mark_present: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAKE_TAB && clr_q == '1) |=> (state == S_MARK_RD))
    else $error("table creation did not return to marking");

endmodule

>>> rtl/core/ptrm_mod.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on nothing; used by the allocation search for alignment tracking.
module ptrm_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);

  logic        run;
  logic [4:0]  cnt;
  logic [31:0] sh;
  logic [32:0] trial;

  // shift in the next dividend bit
  assign trial = {rem, sh[31]};

  // restoring step per cycle, done after the last bit
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        rem <= '0;
        sh <= dividend;
      end else if (run) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= 32'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[31:0];
        end
        sh <= {sh[30:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run)) else $error("remainder done without a running pass");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !run) else $error("remainder restarted mid pass");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("remainder done held two cycles");

endmodule
